// File: hw/rtl/lpfr_pkg.sv
// lpfr_pkg: shared types and constants for the LRU page frame replacement block.
// No dependencies; imported by lpfr_cell and lru_page_frame_replacement.
`timescale 1ns / 1ps
`default_nettype none

package lpfr_pkg;

    localparam int FRAMES_DEF          = 8;
    localparam int PAGE_BITS_DEF       = 16;
    localparam int PAGE_FIELD_W        = 16;
    localparam int CNT_FIELD_W         = 4;
    localparam int FRAMES_IN_USE_RESET = 5;
    localparam int FAULT_W             = 16;

    // Flags rippled from cell to cell.
    typedef struct packed {
        logic hit;           // some earlier cell holds the page
        logic free_seen;     // some earlier active cell is empty
        logic rank_present;  // some earlier valid cell holds rank pack_rank
        logic rank_above;    // some earlier valid cell holds a rank above pack_rank
    } lpfr_link_t;

    // Broadcast controls from the top level to every cell.
    typedef struct packed {
        logic load;          // request accepted this cycle
        logic hit_mode;      // request hits a resident page
        logic free_mode;     // miss, fill the first empty active frame
        logic cfg;           // frame count write
        logic pack_dec;      // close one gap in the rank order
    } lpfr_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/lpfr_cell.sv
// lpfr_cell: one page frame (page, valid bit, recency rank) of the LRU chain.
// Depends on lpfr_pkg for the link and control structs.
`timescale 1ns / 1ps
`default_nettype none

module lpfr_cell
    import lpfr_pkg::*;
#(
    parameter int IDX       = 0,
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    parameter int RANK_W    = 3,
    parameter int CNT_W     = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire lpfr_link_t           link_in,
    output lpfr_link_t                link_out,
    input  wire logic [RANK_W-1:0]    hit_rank_in,
    output logic      [RANK_W-1:0]    hit_rank_out,
    input  wire logic [PAGE_BITS-1:0] victim_page_in,
    output logic      [PAGE_BITS-1:0] victim_page_out,
    input  wire lpfr_ctl_t            ctl,
    input  wire logic [PAGE_BITS-1:0] page,
    input  wire logic [RANK_W-1:0]    limit_rank,
    input  wire logic [RANK_W-1:0]    last_rank,
    input  wire logic [RANK_W-1:0]    pack_rank,
    input  wire logic [CNT_W-1:0]     n_active,
    input  wire logic [CNT_W-1:0]     cfg_count
);

    logic [PAGE_BITS-1:0] page_reg;
    logic                 valid_reg;
    logic                 valid_next;
    logic [RANK_W-1:0]    rank_reg;
    logic [RANK_W-1:0]    rank_next;
    logic                 active;
    logic                 match;
    logic                 my_free;
    logic                 my_victim;
    logic                 slot;

    assign active    = CNT_W'(IDX) < n_active;
    assign match     = valid_reg && (page_reg == page);
    assign my_free   = active && !valid_reg && !link_in.free_seen;
    assign my_victim = valid_reg && (rank_reg == last_rank);
    assign slot      = ctl.hit_mode  ? match   :
                       ctl.free_mode ? my_free : my_victim;

    always_comb begin
        link_out.hit          = link_in.hit | match;
        link_out.free_seen    = link_in.free_seen | (active && !valid_reg);
        link_out.rank_present = link_in.rank_present | (valid_reg && rank_reg == pack_rank);
        link_out.rank_above   = link_in.rank_above | (valid_reg && rank_reg > pack_rank);
        hit_rank_out          = hit_rank_in | (match ? rank_reg : '0);
        victim_page_out       = victim_page_in | (my_victim ? page_reg : '0);
    end

    always_comb begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        priority if (ctl.cfg) begin
            if (!(CNT_W'(IDX) < cfg_count)) begin
                valid_next = 1'b0;
                rank_next  = '0;
            end
        end else if (ctl.pack_dec) begin
            if (valid_reg && rank_reg > pack_rank) begin
                rank_next = rank_reg - 1'b1;
            end
        end else if (ctl.load) begin
            if (slot) begin
                valid_next = 1'b1;
                rank_next  = '0;
            end else if (valid_reg && (ctl.free_mode || rank_reg < limit_rank)) begin
                rank_next = rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load && !ctl.cfg && !ctl.pack_dec && slot) begin
            page_reg <= page;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lru_page_frame_replacement.sv
// A page reference's result reaches the output register in the cycle after it is taken.
// Throughput: one reference per cycle unless m_ready stalls the output; the tag compare and rank
// update ripple through FRAMES cells. A frame count write blocks requests; a rank repack follows.
// Reset (synchronous, aresetn low): all frames empty, fault count zero, frame count min(5, FRAMES).
// Top level: chain of lpfr_cell frames plus control; depends on lpfr_pkg and lpfr_cell.
`timescale 1ns / 1ps
`default_nettype none

module lru_page_frame_replacement
    import lpfr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CNT_FIELD_W-1:0]  cfg_frames_in_use,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [PAGE_FIELD_W-1:0] s_page_number,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic                         m_hit,
    output logic                         m_evicted,
    output logic [PAGE_FIELD_W-1:0]      m_evicted_page,
    output logic [FAULT_W-1:0]           m_fault_count
);

    localparam int RANK_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W  = $clog2(FRAMES + 1);
    localparam int RST_N  = (FRAMES_IN_USE_RESET > FRAMES) ? FRAMES : FRAMES_IN_USE_RESET;

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_PACK = 2'b10
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          n_active_reg, n_active_next;
    logic [RANK_W-1:0]         pack_rank_reg, pack_rank_next;
    logic [FAULT_W-1:0]        fault_cnt_reg, fault_cnt_next;

    logic                      m_valid_reg;
    logic                      m_hit_reg;
    logic                      m_evicted_reg;
    logic [PAGE_FIELD_W-1:0]   m_evicted_page_reg;

    lpfr_link_t                link   [FRAMES+1];
    logic [RANK_W-1:0]         hrank  [FRAMES+1];
    logic [PAGE_BITS-1:0]      vpage  [FRAMES+1];

    lpfr_ctl_t                 ctl;
    logic                      load;
    logic                      cfg_wr;
    logic [PAGE_BITS-1:0]      page;
    logic [PAGE_BITS+PAGE_FIELD_W-1:0] page_ext;
    logic [PAGE_BITS+PAGE_FIELD_W-1:0] victim_ext;
    logic [CNT_FIELD_W+CNT_W-1:0]      cfg_wide;
    logic [CNT_W-1:0]          cfg_count;
    logic [CNT_W-1:0]          n_minus;
    logic [RANK_W-1:0]         last_rank;
    logic [RANK_W-1:0]         limit_rank;
    logic                      hit_any;
    logic                      free_any;

    assign cfg_ready = (state_reg == ST_RUN);
    assign s_ready   = (state_reg == ST_RUN) && !cfg_valid && (!m_valid_reg || m_ready);
    assign load      = s_valid && s_ready;
    assign cfg_wr    = cfg_valid && cfg_ready;

    assign page_ext = {{PAGE_BITS{1'b0}}, s_page_number};
    assign page     = page_ext[PAGE_BITS-1:0];

    assign cfg_wide  = {{CNT_W{1'b0}}, cfg_frames_in_use};
    always_comb begin
        priority if (cfg_wide == '0) begin
            cfg_count = CNT_W'(1);
        end else if (cfg_wide > (CNT_FIELD_W + CNT_W)'(FRAMES)) begin
            cfg_count = CNT_W'(FRAMES);
        end else begin
            cfg_count = cfg_wide[CNT_W-1:0];
        end
    end

    assign n_minus    = n_active_reg - 1'b1;
    assign last_rank  = n_minus[RANK_W-1:0];
    assign hit_any    = link[FRAMES].hit;
    assign free_any   = link[FRAMES].free_seen;
    assign limit_rank = hit_any ? hrank[FRAMES] : last_rank;

    assign link[0]  = '0;
    assign hrank[0] = '0;
    assign vpage[0] = '0;

    always_comb begin
        ctl.load      = load;
        ctl.hit_mode  = hit_any;
        ctl.free_mode = !hit_any && free_any;
        ctl.cfg       = cfg_wr;
        ctl.pack_dec  = (state_reg == ST_PACK) && !link[FRAMES].rank_present
                        && link[FRAMES].rank_above;
    end

    for (genvar i = 0; i < FRAMES; i++) begin : g_cell
        lpfr_cell #(
            .IDX       (i),
            .PAGE_BITS (PAGE_BITS),
            .RANK_W    (RANK_W),
            .CNT_W     (CNT_W)
        ) u_cell (
            .aclk            (aclk),
            .aresetn         (aresetn),
            .link_in         (link[i]),
            .link_out        (link[i+1]),
            .hit_rank_in     (hrank[i]),
            .hit_rank_out    (hrank[i+1]),
            .victim_page_in  (vpage[i]),
            .victim_page_out (vpage[i+1]),
            .ctl             (ctl),
            .page            (page),
            .limit_rank      (limit_rank),
            .last_rank       (last_rank),
            .pack_rank       (pack_rank_reg),
            .n_active        (n_active_reg),
            .cfg_count       (cfg_count)
        );
    end

    assign victim_ext = {{PAGE_FIELD_W{1'b0}}, vpage[FRAMES]};

    always_comb begin
        state_next     = state_reg;
        n_active_next  = n_active_reg;
        pack_rank_next = pack_rank_reg;
        fault_cnt_next = fault_cnt_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (cfg_wr) begin
                    n_active_next  = cfg_count;
                    pack_rank_next = '0;
                    state_next     = ST_PACK;
                end else if (load && !hit_any && fault_cnt_reg != '1) begin
                    fault_cnt_next = fault_cnt_reg + 1'b1;
                end
            end
            ST_PACK: begin
                if (!link[FRAMES].rank_above) begin
                    state_next = ST_RUN;
                end else if (link[FRAMES].rank_present) begin
                    pack_rank_next = pack_rank_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RUN;
            n_active_reg  <= CNT_W'(RST_N);
            pack_rank_reg <= '0;
            fault_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            n_active_reg  <= n_active_next;
            pack_rank_reg <= pack_rank_next;
            fault_cnt_reg <= fault_cnt_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_hit_reg          <= hit_any;
            m_evicted_reg      <= !hit_any && !free_any;
            m_evicted_page_reg <= (!hit_any && !free_any) ? victim_ext[PAGE_FIELD_W-1:0] : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_hit          = m_hit_reg;
    assign m_evicted      = m_evicted_reg;
    assign m_evicted_page = m_evicted_page_reg;
    assign m_fault_count  = fault_cnt_reg;

`ifndef ASSERT_OFF
    a_result_from_request: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s_valid && s_ready))
        else $error("result appeared without a request");

    a_pack_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PACK) |-> (!s_ready && !cfg_ready))
        else $error("request taken during rank repack");

    a_fault_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !hit_any && !cfg_wr) |=>
            (fault_cnt_reg == $past(fault_cnt_reg) + 1'b1 || $past(fault_cnt_reg) == '1))
        else $error("fault counter did not advance on a miss");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && hit_any) |=> (m_hit_reg && !m_evicted_reg))
        else $error("hit reported with eviction");
`endif

endmodule

`default_nettype wire
